// File: rtl/branch_predictor_evaluator_unit_macros.svh
// assertion helpers used by the predictor evaluator back end
`ifndef BRANCH_PREDICTOR_EVALUATOR_UNIT_MACROS_SVH
`define BRANCH_PREDICTOR_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define BPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpe assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define BPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpe assertion failed: next-cycle implication");

`endif

// File: rtl/bpe_pkg.sv
package bpe_pkg;

  localparam int PC_W           = 32;
  localparam int CNT_W          = 32;
  localparam int INDEX_BITS_DEF = 8;
  localparam int Q_DEPTH        = 2;

  localparam logic [PC_W-1:0] SEQ_STEP = PC_W'(4);
  localparam logic [1:0]      CTR_MAX  = 2'd3;

  // classified branch word passed from front to back
  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic            taken;
    logic [PC_W-1:0] target;
    logic [PC_W-1:0] seq;
  } item_t;

  typedef struct packed {
    logic             actually_taken;
    logic             one_bit_taken;
    logic [PC_W-1:0]  one_bit_target;
    logic             two_bit_taken;
    logic [PC_W-1:0]  two_bit_target;
    logic             one_bit_correct;
    logic             two_bit_correct;
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] always_taken_hits;
    logic [CNT_W-1:0] always_not_taken_hits;
    logic [CNT_W-1:0] one_bit_hits;
    logic [CNT_W-1:0] two_bit_hits;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

// File: rtl/bpe_ram.sv
module bpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/bpe_fifo.sv
module bpe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/bpe_front.sv
module bpe_front
  import bpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [PC_W-1:0]        branch_pc,
  input  logic signed [PC_W-1:0] branch_offset,
  input  logic [PC_W-1:0]        next_pc,
  input  logic                   hold,
  output logic                   q_push,
  output item_t                  q_data,
  input  logic                   q_full
);

  logic  stage_valid;
  item_t stage;
  item_t classified;
  logic  accept;

  assign full   = hold || (stage_valid && q_full);
  assign accept = push && !full;
  assign q_push = stage_valid && !q_full;
  assign q_data = stage;

  // taken when the actual step from pc equals the offset, mod 2^32
  always_comb begin
    classified.pc     = branch_pc;
    classified.taken  = ((next_pc - branch_pc) == PC_W'(unsigned'(branch_offset)));
    classified.target = branch_pc + PC_W'(unsigned'(branch_offset));
    classified.seq    = branch_pc + SEQ_STEP;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (q_push) begin
      stage_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/bpe_back.sv
`include "branch_predictor_evaluator_unit_macros.svh"

module bpe_back
  import bpe_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  item_t   q_data,
  output logic    q_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res_data,
  output logic    clearing
);

  localparam int DEPTH    = 1 << INDEX_BITS;
  localparam int TAG_BITS = PC_W - 1 - INDEX_BITS;

  typedef struct packed {
    logic                valid;
    logic [TAG_BITS-1:0] tag;
    logic                last;
    logic [1:0]          ctr;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [INDEX_BITS-1:0] clr_idx;
  item_t                 cur;
  logic [CNT_W-1:0]      total_cnt;
  logic [CNT_W-1:0]      taken_cnt;
  logic [CNT_W-1:0]      not_taken_cnt;
  logic [CNT_W-1:0]      one_bit_cnt;
  logic [CNT_W-1:0]      two_bit_cnt;

  logic [CNT_W-1:0]      total_next;
  logic [CNT_W-1:0]      taken_next;
  logic [CNT_W-1:0]      not_taken_next;
  logic [CNT_W-1:0]      one_bit_next;
  logic [CNT_W-1:0]      two_bit_next;

  logic [INDEX_BITS-1:0] cur_idx;
  logic [TAG_BITS-1:0]   cur_tag;
  logic [$bits(entry_t)-1:0] rd_raw;
  entry_t                rd_entry;
  entry_t                new_entry;
  logic                  hit;
  logic                  old_last;
  logic [1:0]            old_ctr;
  logic [1:0]            new_ctr;
  logic                  c1;
  logic                  c2;
  logic                  update;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  entry_t                wr_data;

  assign clearing = (state == ST_CLEAR);
  assign update   = (state == ST_UPDATE);
  assign q_pop    = (state == ST_IDLE) && !q_empty && !res_full;
  assign res_push = update;

  assign cur_idx  = cur.pc[INDEX_BITS:1];
  assign cur_tag  = cur.pc[PC_W-1:INDEX_BITS+1];
  assign rd_entry = entry_t'(rd_raw);

  bpe_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (q_pop),
    .rd_addr (q_data.pc[INDEX_BITS:1]),
    .rd_data (rd_raw)
  );

  // a miss claims the entry with both predictors at not taken
  always_comb begin
    hit      = rd_entry.valid && (rd_entry.tag == cur_tag);
    old_last = hit ? rd_entry.last : 1'b0;
    old_ctr  = hit ? rd_entry.ctr : 2'd0;
    c1       = (old_last == cur.taken);
    c2       = (old_ctr[1] == cur.taken);
    if (cur.taken) begin
      new_ctr = (old_ctr == CTR_MAX) ? old_ctr : old_ctr + 2'd1;
    end else begin
      new_ctr = (old_ctr == 2'd0) ? old_ctr : old_ctr - 2'd1;
    end
    new_entry.valid = 1'b1;
    new_entry.tag   = cur_tag;
    new_entry.last  = cur.taken;
    new_entry.ctr   = new_ctr;
  end

  always_comb begin
    wr_en   = clearing || update;
    wr_addr = clearing ? clr_idx : cur_idx;
    wr_data = clearing ? entry_t'('0) : new_entry;
  end

  always_comb begin
    total_next     = sat_inc(total_cnt);
    taken_next     = cur.taken ? sat_inc(taken_cnt) : taken_cnt;
    not_taken_next = cur.taken ? not_taken_cnt : sat_inc(not_taken_cnt);
    one_bit_next   = c1 ? sat_inc(one_bit_cnt) : one_bit_cnt;
    two_bit_next   = c2 ? sat_inc(two_bit_cnt) : two_bit_cnt;
  end

  always_comb begin
    res_data.actually_taken        = cur.taken;
    res_data.one_bit_taken         = cur.taken;
    res_data.one_bit_target        = cur.taken ? cur.target : cur.seq;
    res_data.two_bit_taken         = new_ctr[1];
    res_data.two_bit_target        = new_ctr[1] ? cur.target : cur.seq;
    res_data.one_bit_correct       = c1;
    res_data.two_bit_correct       = c2;
    res_data.total_count           = total_next;
    res_data.always_taken_hits     = taken_next;
    res_data.always_not_taken_hits = not_taken_next;
    res_data.one_bit_hits          = one_bit_next;
    res_data.two_bit_hits          = two_bit_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (&clr_idx) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      total_cnt     <= '0;
      taken_cnt     <= '0;
      not_taken_cnt <= '0;
      one_bit_cnt   <= '0;
      two_bit_cnt   <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + INDEX_BITS'(1);
      end
      if (update) begin
        total_cnt     <= total_next;
        taken_cnt     <= taken_next;
        not_taken_cnt <= not_taken_next;
        one_bit_cnt   <= one_bit_next;
        two_bit_cnt   <= two_bit_next;
      end
    end
  end

  // room in the result queue is checked before the table read is issued
  `BPE_ASSERT_IMPL(a_push_has_room, clk, rst, res_push, !res_full)
  `BPE_ASSERT_NEXT(a_pop_then_update, clk, rst, q_pop, state == ST_UPDATE)
  `BPE_ASSERT_NEXT(a_total_moves, clk, rst, update,
                   (total_cnt != $past(total_cnt)) || (&$past(total_cnt)))

endmodule

// File: rtl/branch_predictor_evaluator_unit.sv
// path: front stage register, item queue, back end table read and update, result queue
// pacing: the back end takes a new branch word only after the read-modify-write of the
//   predictor table (registered ram read, then write back) for the last one is done
// reset: synchronous, active high; afterwards a clearing pass over all 2^INDEX_BITS
//   entries zeroes the table, with full held high until it ends
module branch_predictor_evaluator_unit
  import bpe_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [PC_W-1:0]        branch_pc,
  input  logic signed [PC_W-1:0] branch_offset,
  input  logic [PC_W-1:0]        next_pc,
  output logic                   empty,
  input  logic                   pop,
  output logic                   actually_taken,
  output logic                   one_bit_taken,
  output logic [PC_W-1:0]        one_bit_target,
  output logic                   two_bit_taken,
  output logic [PC_W-1:0]        two_bit_target,
  output logic                   one_bit_correct,
  output logic                   two_bit_correct,
  output logic [CNT_W-1:0]       total_count,
  output logic [CNT_W-1:0]       always_taken_hits,
  output logic [CNT_W-1:0]       always_not_taken_hits,
  output logic [CNT_W-1:0]       one_bit_hits,
  output logic [CNT_W-1:0]       two_bit_hits
);

  logic    clearing;
  logic    iq_push;
  item_t   iq_wdata;
  logic    iq_full;
  logic    iq_pop;
  logic [$bits(item_t)-1:0] iq_rdata;
  logic    iq_empty;
  logic    oq_push;
  result_t oq_wdata;
  logic    oq_full;
  logic [$bits(result_t)-1:0] oq_rdata;
  result_t res;

  bpe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .branch_pc     (branch_pc),
    .branch_offset (branch_offset),
    .next_pc       (next_pc),
    .hold          (clearing),
    .q_push        (iq_push),
    .q_data        (iq_wdata),
    .q_full        (iq_full)
  );

  bpe_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (Q_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (iq_push),
    .wdata (iq_wdata),
    .full  (iq_full),
    .pop   (iq_pop),
    .rdata (iq_rdata),
    .empty (iq_empty)
  );

  bpe_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (iq_empty),
    .q_data   (item_t'(iq_rdata)),
    .q_pop    (iq_pop),
    .res_full (oq_full),
    .res_push (oq_push),
    .res_data (oq_wdata),
    .clearing (clearing)
  );

  bpe_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (Q_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign res                   = result_t'(oq_rdata);
  assign actually_taken        = res.actually_taken;
  assign one_bit_taken         = res.one_bit_taken;
  assign one_bit_target        = res.one_bit_target;
  assign two_bit_taken         = res.two_bit_taken;
  assign two_bit_target        = res.two_bit_target;
  assign one_bit_correct       = res.one_bit_correct;
  assign two_bit_correct       = res.two_bit_correct;
  assign total_count           = res.total_count;
  assign always_taken_hits     = res.always_taken_hits;
  assign always_not_taken_hits = res.always_not_taken_hits;
  assign one_bit_hits          = res.one_bit_hits;
  assign two_bit_hits          = res.two_bit_hits;

endmodule

// File: test/tb.sv
module tb;
  import bpe_pkg::*;

  localparam int IDX_W = INDEX_BITS_DEF;
  localparam int TAG_W = PC_W - IDX_W - 1;
  localparam int SLOTS = 1 << IDX_W;
  localparam logic [PC_W-1:0] IDX_MASK = ((PC_W'(1) << IDX_W) - 1) << 1;
  localparam int N_DIRECTED = 21;
  localparam int N_RANDOM = 1030;
  localparam int POOL_N = 24;

  typedef struct {
    logic [PC_W-1:0] pc;
    logic [PC_W-1:0] offset;
    logic [PC_W-1:0] npc;
    bit              known;
    result_t         want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [PC_W-1:0] branch_pc = '0;
  logic signed [PC_W-1:0] branch_offset = '0;
  logic [PC_W-1:0] next_pc = '0;
  logic full, empty;
  logic actually_taken, one_bit_taken, two_bit_taken, one_bit_correct, two_bit_correct;
  logic [PC_W-1:0] one_bit_target, two_bit_target;
  logic [CNT_W-1:0] total_count, always_taken_hits, always_not_taken_hits;
  logic [CNT_W-1:0] one_bit_hits, two_bit_hits;

  branch_predictor_evaluator_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .branch_pc(branch_pc), .branch_offset(branch_offset), .next_pc(next_pc),
    .empty(empty), .pop(pop),
    .actually_taken(actually_taken), .one_bit_taken(one_bit_taken),
    .one_bit_target(one_bit_target), .two_bit_taken(two_bit_taken),
    .two_bit_target(two_bit_target), .one_bit_correct(one_bit_correct),
    .two_bit_correct(two_bit_correct), .total_count(total_count),
    .always_taken_hits(always_taken_hits), .always_not_taken_hits(always_not_taken_hits),
    .one_bit_hits(one_bit_hits), .two_bit_hits(two_bit_hits)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor copy of the table and the hit counters
  logic [TAG_W-1:0] tag_mem [SLOTS];
  bit               valid_mem [SLOTS];
  bit               last_mem [SLOTS];
  logic [1:0]       ctr_mem [SLOTS];
  logic [CNT_W-1:0] seen_total = '0;
  logic [CNT_W-1:0] taken_total = '0;
  logic [CNT_W-1:0] not_taken_total = '0;
  logic [CNT_W-1:0] one_bit_total = '0;
  logic [CNT_W-1:0] two_bit_total = '0;

  result_t verdict_q [$];
  int mismatch_count = 0;
  int idle_pct = 38;
  bit calm = 1'b0;

  logic [PC_W-1:0] pool_pc [POOL_N];
  logic [PC_W-1:0] pool_off [POOL_N];
  int              pool_bias [POOL_N];

  row_t plan [N_DIRECTED] = '{
    // first branch after reset, taken
    '{32'h0000_1000, 32'h0000_0008, 32'h0000_1008, 1'b1,
      '{1'b1, 1'b1, 32'h0000_1008, 1'b0, 32'h0000_1004, 1'b0, 1'b0,
        32'd1, 32'd1, 32'd0, 32'd0, 32'd0}},
    // same branch falls through
    '{32'h0000_1000, 32'h0000_0008, 32'h0000_1004, 1'b1,
      '{1'b0, 1'b0, 32'h0000_1004, 1'b0, 32'h0000_1004, 1'b0, 1'b1,
        32'd2, 32'd1, 32'd1, 32'd0, 32'd1}},
    // top of memory, backward taken, fall-through wraps to zero
    '{32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'hFFFF_FFF8, 1'b1,
      '{1'b1, 1'b1, 32'hFFFF_FFF8, 1'b0, 32'h0000_0000, 1'b0, 1'b0,
        32'd3, 32'd2, 32'd1, 32'd0, 32'd1}},
    '{32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0003, 1'b0, '0},
    '{32'h1234_5678, 32'h0000_0004, 32'h1234_567C, 1'b0, '0},
    // drive the counter into saturation, then one miss
    '{32'h0000_2000, 32'h0000_0040, 32'h0000_2040, 1'b0, '0},
    '{32'h0000_2000, 32'h0000_0040, 32'h0000_2040, 1'b0, '0},
    '{32'h0000_2000, 32'h0000_0040, 32'h0000_2040, 1'b0, '0},
    '{32'h0000_2000, 32'h0000_0040, 32'h0000_2040, 1'b0, '0},
    '{32'h0000_2000, 32'h0000_0040, 32'h0000_2004, 1'b0, '0},
    '{32'h0000_2000, 32'h0000_0040, 32'h0000_2040, 1'b0, '0},
    // same index, other tag: evicts the trained entry
    '{32'h0000_2200, 32'h0000_0040, 32'h0000_2240, 1'b0, '0},
    '{32'h0000_2000, 32'h0000_0040, 32'h0000_2040, 1'b0, '0},
    '{32'h0000_2001, 32'h0000_0040, 32'h0000_2005, 1'b0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5554, 32'h5555_5555, 1'b0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAB, 32'h0000_0000, 1'b0, '0},
    '{32'h8000_0000, 32'hFFFF_FF00, 32'h7FFF_FF00, 1'b0, '0},
    '{32'h8000_0000, 32'hFFFF_FF00, 32'h8000_0004, 1'b0, '0}
  };

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic result_t predict_branch(input logic [PC_W-1:0] pc, off, npc);
    result_t r;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tg;
    logic [PC_W-1:0] jump, fall;
    logic taken, hit1, hit2;
    logic [1:0] ctr;
    idx = pc[IDX_W:1];
    tg = pc[PC_W-1:IDX_W+1];
    jump = pc + off;
    fall = pc + SEQ_STEP;
    taken = (npc - pc) == off;
    if (!valid_mem[idx] || tag_mem[idx] != tg) begin
      valid_mem[idx] = 1'b1;
      tag_mem[idx] = tg;
      last_mem[idx] = 1'b0;
      ctr_mem[idx] = 2'd0;
    end
    ctr = ctr_mem[idx];
    hit1 = last_mem[idx] == taken;
    hit2 = ctr[1] == taken;
    last_mem[idx] = taken;
    if (taken && ctr != CTR_MAX) ctr = ctr + 2'd1;
    else if (!taken && ctr != 2'd0) ctr = ctr - 2'd1;
    ctr_mem[idx] = ctr;
    seen_total = bump(seen_total);
    if (taken) taken_total = bump(taken_total);
    else not_taken_total = bump(not_taken_total);
    if (hit1) one_bit_total = bump(one_bit_total);
    if (hit2) two_bit_total = bump(two_bit_total);
    r.actually_taken = taken;
    r.one_bit_taken = taken;
    r.one_bit_target = taken ? jump : fall;
    r.two_bit_taken = ctr[1];
    r.two_bit_target = ctr[1] ? jump : fall;
    r.one_bit_correct = hit1;
    r.two_bit_correct = hit2;
    r.total_count = seen_total;
    r.always_taken_hits = taken_total;
    r.always_not_taken_hits = not_taken_total;
    r.one_bit_hits = one_bit_total;
    r.two_bit_hits = two_bit_total;
    return r;
  endfunction

  // new branch site; about a third share an index with another site
  function automatic void fresh_slot(input int k);
    int j;
    logic [PC_W-1:0] r;
    r = $urandom;
    j = $urandom_range(POOL_N - 1);
    if ($urandom_range(2) == 0) pool_pc[k] = (r & ~IDX_MASK) | (pool_pc[j] & IDX_MASK);
    else pool_pc[k] = r;
    if ($urandom_range(3) == 0) pool_off[k] = $urandom;
    else pool_off[k] = PC_W'($urandom_range(8191)) - PC_W'(4096);
    case ($urandom_range(3))
      0: pool_bias[k] = $urandom_range(100);
      1: pool_bias[k] = $urandom_range(10);
      default: pool_bias[k] = $urandom_range(90, 100);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [PC_W-1:0] got, want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [PC_W-1:0] got, want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_branch(input logic [PC_W-1:0] pc, off, npc,
                             input bit known, input result_t typed);
    result_t guess;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    branch_pc <= pc;
    branch_offset <= off;
    next_pc <= npc;
    @(posedge clk);
    while (full) @(posedge clk);
    guess = predict_branch(pc, off, npc);
    verdict_q.insert(verdict_q.size(), known ? typed : guess);
  endtask

  // result side: check each popped word, then decide the next pop
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("word with nothing expected, total_count", total_count, '0);
        end else begin
          want = verdict_q.pop_front();
          check_field("actually_taken", actually_taken, want.actually_taken);
          check_field("one_bit_taken", one_bit_taken, want.one_bit_taken);
          check_field("one_bit_target", one_bit_target, want.one_bit_target);
          check_field("two_bit_taken", two_bit_taken, want.two_bit_taken);
          check_field("two_bit_target", two_bit_target, want.two_bit_target);
          check_field("one_bit_correct", one_bit_correct, want.one_bit_correct);
          check_field("two_bit_correct", two_bit_correct, want.two_bit_correct);
          check_field("total_count", total_count, want.total_count);
          check_field("always_taken_hits", always_taken_hits, want.always_taken_hits);
          check_field("always_not_taken_hits", always_not_taken_hits,
                      want.always_not_taken_hits);
          check_field("one_bit_hits", one_bit_hits, want.one_bit_hits);
          check_field("two_bit_hits", two_bit_hits, want.two_bit_hits);
        end
      end
      pop <= calm || ($urandom_range(99) >= 38);
    end
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int i, k;
    bit taken;
    logic [PC_W-1:0] pc, off, npc;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++) begin
      send_branch(plan[i].pc, plan[i].offset, plan[i].npc, plan[i].known, plan[i].want);
    end

    // let the pipe drain completely before the random part
    push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);

    // seed every site first so index sharing never copies unknown bits
    for (k = 0; k < POOL_N; k++) pool_pc[k] = $urandom;
    for (k = 0; k < POOL_N; k++) fresh_slot(k);
    for (i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 300 && i < 500);
      idle_pct = calm ? 0 : 38;
      if (i % 48 == 47) fresh_slot($urandom_range(POOL_N - 1));
      if ($urandom_range(99) < 85) begin
        k = $urandom_range(POOL_N - 1);
        pc = pool_pc[k];
        off = pool_off[k];
        taken = $urandom_range(99) < pool_bias[k];
        npc = taken ? pc + off : pc + SEQ_STEP;
      end else begin
        pc = $urandom;
        off = $urandom;
        npc = ($urandom_range(2) == 0) ? pc + off : $urandom;
      end
      send_branch(pc, off, npc, 1'b0, '0);
    end

    push <= 1'b0;
    calm = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bpe_pkg.sv
rtl/bpe_ram.sv
rtl/bpe_fifo.sv
rtl/bpe_front.sv
rtl/bpe_back.sv
rtl/branch_predictor_evaluator_unit.sv
test/tb.sv
